### design/spd_pkg.sv
// shared types and constants of the servo packet deframer
package spd_pkg;

    localparam logic [7:0] HDR_BYTE = 8'hff;
    localparam logic [7:0] V2_MARK  = 8'hfd;

    localparam logic [16:0] V1_LEN_POS = 17'd3;
    localparam logic [16:0] V2_LEN_POS = 17'd6;

    localparam logic [2:0] PH_HUNT1 = 3'd0;
    localparam logic [2:0] PH_HUNT2 = 3'd1;
    localparam logic [2:0] PH_VER   = 3'd2;
    localparam logic [2:0] PH_HDR   = 3'd3;
    localparam logic [2:0] PH_BODY  = 3'd4;

    typedef struct packed {
        logic [2:0]  phase;
        logic        version;
        logic [7:0]  len_lo;
        logic [15:0] remaining;
        logic [16:0] offset;
    } parse_state_t;

    typedef struct packed {
        logic [7:0]  data_byte;
        logic        in_frame;
        logic        header_found;
        logic        protocol_version;
        logic [16:0] frame_position;
        logic [15:0] declared_length;
        logic        frame_last;
    } frame_result_t;

endpackage

### design/spd_step.sv
// per-byte framing decision and next parser state
module spd_step
    import spd_pkg::*;
(
    input  parse_state_t  cur_state,
    input  logic [7:0]    rx_byte,
    input  logic          abort_frame,
    output parse_state_t  next_state,
    output frame_result_t result
);

    logic [16:0] pos;
    logic [16:0] len_pos;
    logic [15:0] len;
    logic [15:0] rem;
    logic [16:0] dlen_wide;

    always_comb begin
        pos       = cur_state.offset + 17'd1;
        len_pos   = cur_state.version ? V2_LEN_POS : V1_LEN_POS;
        len       = cur_state.version ? {rx_byte, cur_state.len_lo} : {8'd0, rx_byte};
        rem       = (cur_state.remaining == 16'd0) ? 16'd0 : cur_state.remaining - 16'd1;
        dlen_wide = pos + {1'b0, rem} - len_pos;

        next_state = cur_state;
        result     = '0;
        result.data_byte = rx_byte;

        if (abort_frame) begin
            next_state = '0;
        end else begin
            unique case (cur_state.phase)
                PH_HUNT2: begin
                    if (rx_byte == HDR_BYTE) begin
                        next_state.phase  = PH_VER;
                        next_state.offset = 17'd1;
                        result.frame_position = 17'd1;
                    end else begin
                        next_state = '0;
                    end
                end
                PH_VER: begin
                    next_state.version = (rx_byte == V2_MARK);
                    next_state.offset  = 17'd2;
                    next_state.phase   = PH_HDR;
                    result.in_frame         = 1'b1;
                    result.header_found     = 1'b1;
                    result.protocol_version = (rx_byte == V2_MARK);
                    result.frame_position   = 17'd2;
                end
                PH_HDR: begin
                    next_state.offset = pos;
                    result.in_frame         = 1'b1;
                    result.protocol_version = cur_state.version;
                    result.frame_position   = pos;
                    if (cur_state.version && pos == V2_LEN_POS - 17'd1) begin
                        next_state.len_lo = rx_byte;
                    end
                    if (pos >= len_pos) begin
                        result.declared_length = len;
                        next_state.remaining   = len;
                        if (len == 16'd0) begin
                            result.frame_last = 1'b1;
                            next_state = '0;
                        end else begin
                            next_state.phase = PH_BODY;
                        end
                    end
                end
                PH_BODY: begin
                    next_state.offset    = pos;
                    next_state.remaining = rem;
                    result.in_frame         = 1'b1;
                    result.protocol_version = cur_state.version;
                    result.frame_position   = pos;
                    result.declared_length  = dlen_wide[15:0];
                    if (rem == 16'd0) begin
                        result.frame_last = 1'b1;
                        next_state = '0;
                    end
                end
                default: begin
                    if (rx_byte == HDR_BYTE) begin
                        next_state = '0;
                        next_state.phase = PH_HUNT2;
                    end else begin
                        next_state = '0;
                    end
                end
            endcase
        end
    end

endmodule

### design/servo_packet_deframer_unit.sv
// servo bus packet deframer top level: byte stream in, tagged byte stream out
// the result of an input transfer appears on the m_ side in the next cycle
// throughput: one byte per cycle while m_tready is high, set by the single result register
// s_tready stays high while the result register is empty or being drained
// reset (aresetn low, synchronous) returns the parser to header hunting
// and empties the result register
module servo_packet_deframer_unit
    import spd_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // rx_byte
    input  logic        s_tuser,   // abort_frame
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // data_byte, frame_position, declared_length, zero pad
    output logic [2:0]  m_tuser,   // in_frame, header_found, protocol_version
    output logic        m_tlast    // frame_last
);

    parse_state_t  state_reg;
    parse_state_t  state_next;
    frame_result_t step_result;
    frame_result_t result_reg;
    logic          m_tvalid_reg;
    logic          s_fire;

    spd_step u_step (
        .cur_state   (state_reg),
        .rx_byte     (s_tdata),
        .abort_frame (s_tuser),
        .next_state  (state_next),
        .result      (step_result)
    );

    assign s_tready = !m_tvalid_reg || m_tready;
    assign s_fire   = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (s_fire) begin
                state_reg    <= state_next;
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            result_reg <= step_result;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {7'd0, result_reg.declared_length, result_reg.frame_position,
                       result_reg.data_byte};
    assign m_tuser  = {result_reg.protocol_version, result_reg.header_found,
                       result_reg.in_frame};
    assign m_tlast  = result_reg.frame_last;

endmodule

### bench/servo_packet_deframer_checker.sv
// checker for the servo packet deframer: tracks transfers, predicts tags, compares results
module servo_packet_deframer_checker
    import spd_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,
    input  logic        s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [47:0] m_tdata,
    input  logic [2:0]  m_tuser,
    input  logic        m_tlast,
    output int          fail_count,
    output int          pending
);
    timeunit 1ns;
    timeprecision 1ps;

    frame_result_t expected_tags[$];

    logic [2:0]  st_phase;
    logic        st_v2;
    logic [7:0]  st_len_lo;
    logic [15:0] st_left;
    logic [16:0] st_offset;

    function void restart_hunt();
        st_phase  = PH_HUNT1;
        st_v2     = 1'b0;
        st_len_lo = 8'h00;
        st_left   = 16'd0;
        st_offset = 17'd0;
    endfunction

    function frame_result_t deframe_byte(input logic [7:0] b, input logic brk);
        frame_result_t r;
        logic [16:0]   len_at;
        logic [15:0]   left_next;
        logic [31:0]   span;
        r = '0;
        r.data_byte = b;
        len_at = st_v2 ? V2_LEN_POS : V1_LEN_POS;
        if (brk) begin
            restart_hunt();
        end else begin
            case (st_phase)
                PH_HUNT2: begin
                    if (b == HDR_BYTE) begin
                        st_phase = PH_VER;
                        st_offset = 17'd1;
                        r.frame_position = 17'd1;
                    end else begin
                        restart_hunt();
                    end
                end
                PH_VER: begin
                    st_v2 = (b == V2_MARK);
                    st_offset = 17'd2;
                    st_phase = PH_HDR;
                    r.in_frame = 1'b1;
                    r.header_found = 1'b1;
                    r.protocol_version = st_v2;
                    r.frame_position = 17'd2;
                end
                PH_HDR: begin
                    st_offset = st_offset + 17'd1;
                    r.in_frame = 1'b1;
                    r.protocol_version = st_v2;
                    r.frame_position = st_offset;
                    if (st_v2 && st_offset == V2_LEN_POS - 17'd1)
                        st_len_lo = b;
                    if (st_offset >= len_at) begin
                        r.declared_length = st_v2 ? {b, st_len_lo} : {8'h00, b};
                        st_left = r.declared_length;
                        if (r.declared_length == 16'd0) begin
                            r.frame_last = 1'b1;
                            restart_hunt();
                        end else begin
                            st_phase = PH_BODY;
                        end
                    end
                end
                PH_BODY: begin
                    left_next = (st_left == 16'd0) ? 16'd0 : st_left - 16'd1;
                    st_offset = st_offset + 17'd1;
                    r.in_frame = 1'b1;
                    r.protocol_version = st_v2;
                    r.frame_position = st_offset;
                    span = 32'(st_offset) + 32'(left_next) - 32'(len_at);
                    r.declared_length = span[15:0];
                    st_left = left_next;
                    if (left_next == 16'd0) begin
                        r.frame_last = 1'b1;
                        restart_hunt();
                    end
                end
                default: begin
                    if (b == HDR_BYTE) begin
                        st_phase = PH_HUNT2;
                        st_offset = 17'd0;
                    end else begin
                        restart_hunt();
                    end
                end
            endcase
        end
        return r;
    endfunction

    task report(input string field, input logic [16:0] want, input logic [16:0] got);
        $display("%0t: %s mismatch, expected %0h actual %0h", $time, field, want, got);
        fail_count++;
    endtask

    always @(posedge aclk) begin
        frame_result_t want;
        frame_result_t got;
        if (!aresetn) begin
            restart_hunt();
            expected_tags.delete();
            fail_count = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                got.data_byte        = m_tdata[7:0];
                got.frame_position   = m_tdata[24:8];
                got.declared_length  = m_tdata[40:25];
                got.in_frame         = m_tuser[0];
                got.header_found     = m_tuser[1];
                got.protocol_version = m_tuser[2];
                got.frame_last       = m_tlast;
                if (expected_tags.size() == 0) begin
                    $display("%0t: result transfer with nothing expected, expected none actual %h",
                             $time, got);
                    fail_count++;
                end else begin
                    want = expected_tags.pop_front();
                    if (got.data_byte !== want.data_byte)
                        report("data_byte", 17'(want.data_byte), 17'(got.data_byte));
                    if (got.in_frame !== want.in_frame)
                        report("in_frame", 17'(want.in_frame), 17'(got.in_frame));
                    if (got.header_found !== want.header_found)
                        report("header_found", 17'(want.header_found),
                               17'(got.header_found));
                    if (got.protocol_version !== want.protocol_version)
                        report("protocol_version", 17'(want.protocol_version),
                               17'(got.protocol_version));
                    if (got.frame_position !== want.frame_position)
                        report("frame_position", want.frame_position, got.frame_position);
                    if (got.declared_length !== want.declared_length)
                        report("declared_length", 17'(want.declared_length),
                               17'(got.declared_length));
                    if (got.frame_last !== want.frame_last)
                        report("frame_last", 17'(want.frame_last), 17'(got.frame_last));
                    if (m_tdata[47:41] !== 7'd0)
                        report("tdata padding", 17'd0, 17'(m_tdata[47:41]));
                end
            end
            if (s_tvalid && s_tready)
                expected_tags.insert(expected_tags.size(), deframe_byte(s_tdata, s_tuser));
        end
        pending <= expected_tags.size();
    end

endmodule

### bench/servo_packet_deframer_unit_test.sv
// testbench top for the servo packet deframer: clock, reset, byte stimulus and verdict
module servo_packet_deframer_unit_test
    import spd_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'h00;
    logic        s_tuser = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;
    logic [2:0]  m_tuser;
    logic        m_tlast;
    int          fail_count;
    int          pending;

    int tx_idle_pct = 33;
    int rx_idle_pct = 70;
    bit hold_req = 1'b0;
    int bytes_sent = 0;

    servo_packet_deframer_unit dut (.*);

    servo_packet_deframer_checker checker_i (.*);

    initial begin
        forever #5 aclk = ~aclk;
    end

    initial begin
        #3_000_000;
        $display("servo_packet_deframer_unit_test: FAIL");
        $finish;
    end

    // receiver side, with one long hold-off on request
    initial begin
        forever begin
            @(posedge aclk);
            if (hold_req) begin
                m_tready <= 1'b0;
                repeat (60) @(posedge aclk);
                hold_req = 1'b0;
            end
            m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    task send_byte(input logic [7:0] b, input logic brk);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= b;
        s_tuser <= brk;
        do @(posedge aclk); while (!s_tready);
        bytes_sent++;
    endtask

    // cut < 0 or cut past the packet end sends the whole packet, otherwise byte cut carries an abort
    task send_packet(input bit v2, input int unsigned len, input int cut);
        int unsigned total;
        int          i;
        logic [7:0]  b;
        total = v2 ? len + 7 : len + 4;
        for (i = 0; i < total; i++) begin
            if (i == cut) begin
                send_byte(8'($urandom_range(0, 255)), 1'b1);
                return;
            end
            b = 8'($urandom_range(0, 255));
            if (i < 2)
                b = HDR_BYTE;
            else if (i == 2)
                b = v2 ? V2_MARK : ((b == V2_MARK) ? HDR_BYTE : b);
            else if (v2 && i == 5)
                b = len[7:0];
            else if (v2 && i == 6)
                b = len[15:8];
            else if (!v2 && i == 3)
                b = len[7:0];
            send_byte(b, 1'b0);
        end
    endtask

    task random_traffic(input int upto);
        int          pick;
        int unsigned len;
        bit          v2;
        int          k;
        while (bytes_sent < upto) begin
            pick = $urandom_range(0, 99);
            v2 = 1'($urandom_range(0, 1));
            if (v2)
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 600) : $urandom_range(0, 6);
            else
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 6);
            if (pick < 75) begin
                send_packet(v2, len, -1);
            end else if (pick < 83) begin
                send_packet(v2, len, $urandom_range(0, 9));
            end else if (pick < 91) begin
                send_byte(HDR_BYTE, 1'b0);
                send_byte(($urandom_range(0, 1) == 0) ? HDR_BYTE : 8'($urandom_range(0, 255)),
                          1'b0);
            end else begin
                for (k = $urandom_range(1, 4); k > 0; k--)
                    send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 9) == 0);
            end
        end
    endtask

    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // version 1 and version 2 packets of zero length
        send_packet(1'b0, 0, -1);
        send_packet(1'b1, 0, -1);
        // broken header
        send_byte(HDR_BYTE, 1'b0);
        send_byte(8'h00, 1'b0);
        // third byte FF taken as a version 1 id
        send_byte(HDR_BYTE, 1'b0);
        send_byte(HDR_BYTE, 1'b0);
        send_byte(HDR_BYTE, 1'b0);
        send_byte(8'h01, 1'b0);
        send_byte(8'hff, 1'b0);
        // abort inside a version 2 header, abort byte FF
        send_byte(HDR_BYTE, 1'b0);
        send_byte(HDR_BYTE, 1'b0);
        send_byte(V2_MARK, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(HDR_BYTE, 1'b1);
        // abort while hunting
        send_byte(8'h5a, 1'b1);

        random_traffic(330);

        tx_idle_pct = 70;
        rx_idle_pct = 33;
        random_traffic(650);

        tx_idle_pct = 0;
        rx_idle_pct = 0;
        hold_req = 1'b1;
        random_traffic(950);
        // full 16-bit length, cut short by an abort in the body
        send_packet(1'b1, 65535, 9);
        s_tvalid <= 1'b0;

        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
        if (fail_count == 0)
            $display("servo_packet_deframer_unit_test: PASS");
        else
            $display("servo_packet_deframer_unit_test: FAIL");
        $finish;
    end

endmodule
